// ----- rtl/core/int_to_decimal_ascii_assert.svh -----
// assertion macros for int_to_decimal_ascii
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define I2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2d check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define I2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2d check failed");

`endif

// ----- rtl/core/i2d_pkg.sv -----
`default_nettype none

package i2d_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  // decimal digits of 2^(VALUE_WIDTH-1)
  localparam int unsigned NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned IDX_W       = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] bin;
    logic [BCD_W-1:0]       bcd;
  } dd_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2d_cell.sv -----
`default_nettype none

module i2d_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  i2d_pkg::dd_word_t data_i,
  output logic              valid_o,
  output i2d_pkg::dd_word_t data_o
);
  import i2d_pkg::*;

  logic             valid_q;
  dd_word_t         data_q;
  dd_word_t         data_d;
  logic [BCD_W-1:0] adj;

  // add 3 to every digit of five or more, then shift one binary bit in
  always_comb begin
    adj = data_i.bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (data_i.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = data_i.bcd[4*i +: 4] + 4'd3;
      end
    end
    data_d.neg = data_i.neg;
    data_d.bcd = {adj[BCD_W-2:0], data_i.bin[VALUE_WIDTH-1]};
    data_d.bin = {data_i.bin[VALUE_WIDTH-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/i2d_emit.sv -----
`default_nettype none

module i2d_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  i2d_pkg::dd_word_t data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        char_code_o,
  output logic              last_o
);
  import i2d_pkg::*;

  logic             busy_q;
  logic             neg_q;
  logic [BCD_W-1:0] bcd_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] top_idx;
  logic [3:0]       digit;
  logic             xfer;
  logic             done;
  logic             load;

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (data_i.bcd[4*i +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign xfer    = busy_q && out_ready_i;
  assign done    = xfer && last_o;
  assign ready_o = !busy_q || done;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= data_i.neg;
      bcd_q <= data_i.bcd;
      idx_q <= top_idx;
    end else if (xfer) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else if (idx_q != '0) begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  assign digit       = bcd_q[{idx_q, 2'b00} +: 4];
  assign out_valid_o = busy_q;
  assign char_code_o = neg_q ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
  assign last_o      = busy_q && !neg_q && (idx_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/int_to_decimal_ascii.sv -----
// the first character is valid once the value has passed all VALUE_WIDTH cells and been loaded into the emitter
// throughput: one character per cycle while out_ready_i is high, so one value per 1 to 11 characters
// (the text length), set by the single output character port
// a row of VALUE_WIDTH shift-and-add-3 cells holds up to VALUE_WIDTH values in flight
// reset: asynchronous, active low, clears the cell valid bits and the emitter busy flag
`default_nettype none

module int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [i2d_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          char_code_o,
  output logic                                last_o
);
  import i2d_pkg::*;

  logic                   cell_valid [VALUE_WIDTH+1];
  dd_word_t               cell_word  [VALUE_WIDTH+1];
  logic [VALUE_WIDTH-1:0] mag;
  logic                   emit_ready;
  logic                   en;

  // magnitude as unsigned, so the most negative value needs no special case
  assign mag = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;

  assign cell_valid[0]    = in_valid_i;
  assign cell_word[0].neg = value_i[VALUE_WIDTH-1];
  assign cell_word[0].bin = mag;
  assign cell_word[0].bcd = '0;

  assign en         = !cell_valid[VALUE_WIDTH] || emit_ready;
  assign in_ready_o = en;

  for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_cell
    i2d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[g]),
      .data_i  (cell_word[g]),
      .valid_o (cell_valid[g+1]),
      .data_o  (cell_word[g+1])
    );
  end

  i2d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cell_valid[VALUE_WIDTH]),
    .data_i      (cell_word[VALUE_WIDTH]),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/i2d_checker.sv -----
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module i2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] char_code_o,
  input logic       last_o
);
  import i2d_pkg::*;

  logic is_minus;
  logic is_zero;
  logic is_digit;

  assign is_minus = (char_code_o == CHAR_MINUS);
  assign is_zero  = (char_code_o == CHAR_ZERO);
  assign is_digit = (char_code_o >= CHAR_ZERO) && (char_code_o <= (CHAR_ZERO + 8'd9));

  `I2D_ASSERT_NOW(a_char_legal, out_valid_o, is_minus || is_digit)
  `I2D_ASSERT_NOW(a_minus_not_last, out_valid_o && is_minus, !last_o)
  `I2D_ASSERT_NEXT(a_no_zero_after_minus, out_valid_o && out_ready_i && is_minus, out_valid_o && !is_minus && !is_zero)
  `I2D_ASSERT_NEXT(a_text_continues, out_valid_o && out_ready_i && !last_o, out_valid_o && !is_minus)
  `I2D_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(char_code_o) && $stable(last_o))

endmodule

bind int_to_decimal_ascii i2d_checker u_i2d_checker (.*);

`default_nettype wire
